### rtl/capt_pkg.sv
// Package: types, sizes, codes and operations of the call arc profile table.
package capt_pkg;

  localparam int CALLER_ENTRIES = 1024;
  localparam int ARC_ENTRIES    = 4096;
  localparam int HASH_BITS      = 16;
  localparam int BUCKETS        = 1 << HASH_BITS;

  localparam int CIDX_W = $clog2(CALLER_ENTRIES);
  localparam int AIDX_W = $clog2(ARC_ENTRIES);
  localparam int CUSE_W = $clog2(CALLER_ENTRIES + 1);
  localparam int AUSE_W = $clog2(ARC_ENTRIES + 1);
  localparam int CAP_W  = 17;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALLER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARC_LIMIT    = 2'd2;

  localparam logic [1:0] ST_RECORDED = 2'd0;
  localparam logic [1:0] ST_SKIPPED  = 2'd1;
  localparam logic [1:0] ST_CFULL    = 2'd2;
  localparam logic [1:0] ST_AFULL    = 2'd3;

  typedef struct packed {
    logic [63:0] return_addr;
    logic [63:0] callee_pc;
    logic [63:0] cycles;
    logic [11:0] parent_arc;
    logic        thread_on;
  } in_item_t;

  typedef struct packed {
    logic [11:0] arc_handle;
    logic [31:0] arc_hits;
    logic [63:0] parent_time;
    logic [1:0]  status;
    logic [31:0] calls_seen;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_SKIP, OP_HELD, OP_PRD, OP_PWR,
    OP_CRD, OP_CNEXT, OP_CHIT, OP_CMTF1, OP_CMTF2, OP_CALLOC, OP_CFULL,
    OP_AHEAD, OP_ARD, OP_ANEXT, OP_AMTF1, OP_AMTF2, OP_AALLOC, OP_AFULL,
    OP_TRD, OP_TWR, OP_FIN, OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START, S_PWR, S_CWALK, S_CCMP, S_CMTF1, S_CMTF2,
    S_CALLOC, S_AHEAD, S_AWALK, S_ACMP, S_AMTF2, S_AALLOC, S_TRD, S_TWR,
    S_FIN, S_OUT
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic skip;
    logic held;
    logic ci_zero;
    logic ckey_hit;
    logic prev_zero;
    logic calloc_ok;
    logic nx_zero;
    logic akey_hit;
    logic pv_zero;
    logic aalloc_ok;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/call_arc_profile_table.sv
// Top level: call arc profile table with move-to-front caller and arc chains.
//
// Input channel in_valid/in_stall/in_item carries one profiled call per item.
// Result channel out_valid/out_stall/out_item returns exactly one item per call.
// Configuration port cfg_we/cfg_idx/cfg_data writes enable, caller_limit and
// arc_limit; writing enable clears the latched table-full status.
// Items are processed one at a time by a sequencer over single-port memories.
// A skipped or held call goes straight to the output. A recorded call reads
// its bucket head, walks the caller chain, moving a found caller to the front
// or allocating a new one, then walks that caller's arc chain, moving a found
// arc to the front and incrementing its hit count or allocating a new arc; a
// call that finds the caller table full stops after the caller walk. Memory
// reads are registered. The next item is taken in the cycle after the result
// is written. A finished result sits in the output register, so the next
// item can be accepted while the receiver stalls; a second result then waits
// in the sequencer until the register frees.
// After reset the block sweeps the 65536 bucket heads to empty, one per
// cycle, holding in_stall high during the sweep; configuration writes are
// taken during the sweep.
module call_arc_profile_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  capt_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output capt_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [capt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [capt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import capt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_stall = !in_ready;

  capt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  capt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### rtl/capt_ctrl.sv
// Controller: sequences one call item through lookup, update and output.
module capt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  capt_pkg::dp_stat_t stat,
  output capt_pkg::dp_cmd_t  cmd
);
  import capt_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_START;
        end
      end
      S_START: begin
        priority if (stat.skip) begin
          cmd.op    = OP_SKIP;
          state_nxt = S_OUT;
        end else if (stat.held) begin
          cmd.op    = OP_HELD;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_PRD;
          state_nxt = S_PWR;
        end
      end
      S_PWR: begin
        cmd.op    = OP_PWR;
        state_nxt = S_CWALK;
      end
      S_CWALK: begin
        if (stat.ci_zero) begin
          state_nxt = S_CALLOC;
        end else begin
          cmd.op    = OP_CRD;
          state_nxt = S_CCMP;
        end
      end
      S_CCMP: begin
        if (stat.ckey_hit) begin
          cmd.op    = OP_CHIT;
          state_nxt = stat.prev_zero ? S_AHEAD : S_CMTF1;
        end else begin
          cmd.op    = OP_CNEXT;
          state_nxt = S_CWALK;
        end
      end
      S_CMTF1: begin
        cmd.op    = OP_CMTF1;
        state_nxt = S_CMTF2;
      end
      S_CMTF2: begin
        cmd.op    = OP_CMTF2;
        state_nxt = S_AHEAD;
      end
      S_CALLOC: begin
        if (stat.calloc_ok) begin
          cmd.op    = OP_CALLOC;
          state_nxt = S_AHEAD;
        end else begin
          cmd.op    = OP_CFULL;
          state_nxt = S_FIN;
        end
      end
      S_AHEAD: begin
        cmd.op    = OP_AHEAD;
        state_nxt = S_AWALK;
      end
      S_AWALK: begin
        if (stat.nx_zero) begin
          state_nxt = S_AALLOC;
        end else begin
          cmd.op    = OP_ARD;
          state_nxt = S_ACMP;
        end
      end
      S_ACMP: begin
        priority if (stat.akey_hit && stat.pv_zero) begin
          state_nxt = S_TRD;
        end else if (stat.akey_hit) begin
          cmd.op    = OP_AMTF1;
          state_nxt = S_AMTF2;
        end else begin
          cmd.op    = OP_ANEXT;
          state_nxt = S_AWALK;
        end
      end
      S_AMTF2: begin
        cmd.op    = OP_AMTF2;
        state_nxt = S_TRD;
      end
      S_AALLOC: begin
        cmd.op    = stat.aalloc_ok ? OP_AALLOC : OP_AFULL;
        state_nxt = S_FIN;
      end
      S_TRD: begin
        cmd.op    = OP_TRD;
        state_nxt = S_TWR;
      end
      S_TWR: begin
        cmd.op    = OP_TWR;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/capt_dp.sv
// Datapath: configuration, counters, hash and arc memories, result register.
module capt_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  capt_pkg::dp_cmd_t                     cmd,
  output capt_pkg::dp_stat_t                    stat,
  input  capt_pkg::in_item_t                    in_item,
  input  logic                                 cfg_we,
  input  logic [capt_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [capt_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output capt_pkg::out_item_t                   out_item
);
  import capt_pkg::*;

  // configuration and counters
  logic              enable_r;
  logic [10:0]       caller_limit_r;
  logic [12:0]       arc_limit_r;
  logic [1:0]        full_r;
  logic [31:0]       total_r;
  logic [CUSE_W-1:0] cused_r;
  logic [AUSE_W-1:0] aused_r;
  logic [HASH_BITS-1:0] clr_r;

  // item and walk registers
  in_item_t          it_r;
  logic [CIDX_W-1:0] ci_r, prev_r, head_r, cnext_r;
  logic [AIDX_W-1:0] ahead_r, nx_r, pv_r;
  logic [11:0]       handle_r;
  logic [31:0]       hits_r;
  logic [63:0]       ptime_r;
  logic [1:0]        status_r;
  logic              out_valid_r;
  out_item_t         out_r;

  // memories
  logic [CIDX_W-1:0] bh_mem [BUCKETS];
  logic [63:0]       ck_mem [CALLER_ENTRIES];
  logic [CIDX_W-1:0] cc_mem [CALLER_ENTRIES];
  logic [AIDX_W-1:0] cah_mem [CALLER_ENTRIES];
  logic [63:0]       ak_mem [ARC_ENTRIES];
  logic [AIDX_W-1:0] ac_mem [ARC_ENTRIES];
  logic [31:0]       tl_mem [ARC_ENTRIES];
  logic [63:0]       tm_mem [ARC_ENTRIES];

  logic [CIDX_W-1:0] bh_rd, cc_rd;
  logic [63:0]       ck_rd, ak_rd, tm_rd;
  logic [AIDX_W-1:0] cah_rd, ac_rd;
  logic [31:0]       tl_rd;

  logic [HASH_BITS-1:0] bucket;
  logic [AIDX_W-1:0]    parent_idx;
  logic                 parent_ok;
  logic [CAP_W-1:0]     ccap, acap, cnew_w, anew_w;
  logic [CIDX_W-1:0]    cnew;
  logic [AIDX_W-1:0]    anew;
  logic [63:0]          tsum;

  assign bucket = it_r.return_addr[63:48] ^ it_r.return_addr[47:32] ^
                  it_r.return_addr[31:16] ^ it_r.return_addr[15:0];
  assign parent_idx = AIDX_W'(it_r.parent_arc);
  assign parent_ok  = (it_r.parent_arc != 12'd0) &&
                      ({1'b0, it_r.parent_arc} < 13'(ARC_ENTRIES));
  assign ccap = (CAP_W'(caller_limit_r) > CAP_W'(CALLER_ENTRIES)) ?
                CAP_W'(CALLER_ENTRIES) : CAP_W'(caller_limit_r);
  assign acap = (CAP_W'(arc_limit_r) > CAP_W'(ARC_ENTRIES)) ?
                CAP_W'(ARC_ENTRIES) : CAP_W'(arc_limit_r);
  assign cnew_w = CAP_W'(cused_r) + CAP_W'(1);
  assign anew_w = CAP_W'(aused_r) + CAP_W'(1);
  assign cnew   = cnew_w[CIDX_W-1:0];
  assign anew   = anew_w[AIDX_W-1:0];
  assign tsum   = tm_rd + it_r.cycles;

  always_comb begin
    stat.clear_last = (clr_r == {HASH_BITS{1'b1}});
    stat.skip       = !enable_r || !it_r.thread_on;
    stat.held       = (full_r != ST_RECORDED);
    stat.ci_zero    = (ci_r == '0);
    stat.ckey_hit   = (ck_rd == it_r.return_addr);
    stat.prev_zero  = (prev_r == '0);
    stat.calloc_ok  = (cnew_w < ccap);
    stat.nx_zero    = (nx_r == '0);
    stat.akey_hit   = (ak_rd == it_r.callee_pc);
    stat.pv_zero    = (pv_r == '0);
    stat.aalloc_ok  = (anew_w < acap);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // bucket heads
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) bh_mem[clr_r] <= '0;
    else if (cmd.op == OP_CMTF1) bh_mem[bucket] <= ci_r;
    else if (cmd.op == OP_CALLOC) bh_mem[bucket] <= cnew;
    if (cmd.op == OP_PRD) bh_rd <= bh_mem[bucket];
  end

  // caller entries
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CALLOC) ck_mem[cnew] <= it_r.return_addr;
    if (cmd.op == OP_CRD) ck_rd <= ck_mem[ci_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CMTF1) cc_mem[prev_r] <= cnext_r;
    else if (cmd.op == OP_CMTF2) cc_mem[ci_r] <= head_r;
    else if (cmd.op == OP_CALLOC) cc_mem[cnew] <= head_r;
    if (cmd.op == OP_CRD) cc_rd <= cc_mem[ci_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CALLOC) cah_mem[cnew] <= '0;
    else if (cmd.op == OP_AMTF1) cah_mem[ci_r] <= nx_r;
    else if (cmd.op == OP_AALLOC) cah_mem[ci_r] <= anew;
    if (cmd.op == OP_CRD) cah_rd <= cah_mem[ci_r];
  end

  // arc entries
  always_ff @(posedge clk) begin
    if (cmd.op == OP_AALLOC) ak_mem[anew] <= it_r.callee_pc;
    if (cmd.op == OP_ARD) ak_rd <= ak_mem[nx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_AMTF1) ac_mem[pv_r] <= ac_rd;
    else if (cmd.op == OP_AMTF2) ac_mem[nx_r] <= ahead_r;
    else if (cmd.op == OP_AALLOC) ac_mem[anew] <= ahead_r;
    if (cmd.op == OP_ARD) ac_rd <= ac_mem[nx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_TWR) tl_mem[nx_r] <= tl_rd + 32'd1;
    else if (cmd.op == OP_AALLOC) tl_mem[anew] <= 32'd1;
    if (cmd.op == OP_TRD) tl_rd <= tl_mem[nx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PWR && parent_ok) tm_mem[parent_idx] <= tsum;
    else if (cmd.op == OP_AALLOC) tm_mem[anew] <= '0;
    if (cmd.op == OP_PRD) tm_rd <= tm_mem[parent_idx];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      caller_limit_r <= 11'd1024;
      arc_limit_r    <= 13'd4096;
      full_r         <= ST_RECORDED;
      total_r        <= '0;
      cused_r        <= '0;
      aused_r        <= '0;
      clr_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) clr_r <= clr_r + 1'b1;
      if (cmd.op == OP_PRD) total_r <= total_r + 32'd1;
      if (cmd.op == OP_CALLOC) cused_r <= cnew_w[CUSE_W-1:0];
      if (cmd.op == OP_AALLOC) aused_r <= anew_w[AUSE_W-1:0];
      if (cmd.op == OP_FIN && (status_r == ST_CFULL || status_r == ST_AFULL)) begin
        full_r <= status_r;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_ENABLE: begin
            enable_r <= cfg_data[0];
            full_r   <= ST_RECORDED;
          end
          REG_CALLER_LIMIT: caller_limit_r <= cfg_data[10:0];
          REG_ARC_LIMIT:    arc_limit_r    <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_EMIT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // item payload and walk
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: it_r <= in_item;
      OP_SKIP, OP_HELD, OP_PRD: begin
        handle_r <= '0;
        hits_r   <= '0;
        ptime_r  <= '0;
        status_r <= (cmd.op == OP_SKIP) ? ST_SKIPPED :
                    (cmd.op == OP_HELD) ? full_r : ST_RECORDED;
      end
      OP_PWR: begin
        if (parent_ok) ptime_r <= tsum;
        ci_r   <= bh_rd;
        head_r <= bh_rd;
        prev_r <= '0;
      end
      OP_CNEXT: begin
        prev_r <= ci_r;
        ci_r   <= cc_rd;
      end
      OP_CHIT: begin
        ahead_r <= cah_rd;
        cnext_r <= cc_rd;
      end
      OP_CALLOC: begin
        ci_r    <= cnew;
        ahead_r <= '0;
      end
      OP_CFULL: status_r <= ST_CFULL;
      OP_AHEAD: begin
        nx_r <= ahead_r;
        pv_r <= '0;
      end
      OP_ANEXT: begin
        pv_r <= nx_r;
        nx_r <= ac_rd;
      end
      OP_AALLOC: begin
        handle_r <= 12'(anew);
        hits_r   <= 32'd1;
      end
      OP_AFULL: status_r <= ST_AFULL;
      OP_TWR: begin
        handle_r <= 12'(nx_r);
        hits_r   <= tl_rd + 32'd1;
      end
      OP_EMIT: begin
        out_r.arc_handle  <= handle_r;
        out_r.arc_hits    <= hits_r;
        out_r.parent_time <= ptime_r;
        out_r.status      <= status_r;
        out_r.calls_seen  <= total_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_cused_range: assert property (@(posedge clk) disable iff (!rst_n)
    CAP_W'(cused_r) < CAP_W'(CALLER_ENTRIES))
    else $error("caller count out of range");

  a_aused_range: assert property (@(posedge clk) disable iff (!rst_n)
    CAP_W'(aused_r) < CAP_W'(ARC_ENTRIES))
    else $error("arc count out of range");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |=> out_valid_r)
    else $error("emitted item not valid");

  a_recorded_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_RECORDED) |-> (out_r.arc_handle != 12'd0))
    else $error("recorded item without arc handle");

endmodule
